>>> sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the stereo feedback delay line: item
// structures, configuration register set and register indexes.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Store geometry and sample format
  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DELAY_W   = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEEDBACK_GAIN = 3'd0,
    CFG_TARGET_DELAY  = 3'd1,
    CFG_INPUT_GAIN    = 3'd2,
    CFG_OUTPUT_GAIN   = 3'd3,
    CFG_SMOOTHING     = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [CFG_W-1:0] FEEDBACK_GAIN_RST = 16'd0;
  localparam logic [CFG_W-1:0] TARGET_DELAY_RST  = 16'd32768;
  localparam logic [CFG_W-1:0] INPUT_GAIN_RST    = 16'd16384;
  localparam logic [CFG_W-1:0] OUTPUT_GAIN_RST   = 16'd16384;
  localparam logic [CFG_W-1:0] SMOOTHING_RST     = 16'd655;

  typedef struct packed {
    logic [CFG_W-1:0] feedback_gain;
    logic [CFG_W-1:0] target_delay;
    logic [CFG_W-1:0] input_gain;
    logic [CFG_W-1:0] output_gain;
    logic [CFG_W-1:0] smoothing;
  } cfg_t;

  // Input item: stereo sample plus modulation offsets
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic signed [15:0]         gain_mod;
    logic signed [15:0]         time_mod;
  } in_item_t;

  // Result item: delayed stereo sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // Sequencer phases of one item
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_RD,
    ST_OUT
  } seq_state_e;

endpackage

>>> sv/stereo_feedback_delay_line.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line
// Stereo delay line with feedback and a gliding, modulated delay time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one stereo
//   sample with gain and time modulation per item. Output channel
//   (out_valid_o / out_stall_i / out_item_o) returns one delayed stereo
//   sample per input item, in order.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 feedback, 1 target delay, 2 input gain, 3 output gain, 4 smoothing).
//   Write only while no item is in flight.
//   Each item runs the four-phase sequence around the single store RAM
//   (multiply, accumulate and write, read, output); the next item starts
//   its multiply phase only once the last has left its output phase.
//   An input register takes the next item while one is in work, and an
//   output register holds a result while the next item is computed.
//   If the receiver stalls, the finished item waits in the output register
//   and the sequencer holds in its output phase until it drains.
//   Reset clears indexes, delay and registers at once; the store reads as
//   zero until written, tracked by the write index and a wrap flag, so no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_line
  import sfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Datapath widths
  localparam int unsigned GAIN_W = CFG_W + 2;
  localparam int unsigned PIN_W  = SAMPLE_W + GAIN_W;
  localparam int unsigned PFB_W  = SAMPLE_W + CFG_W + 1;
  localparam int unsigned ACC_W  = PIN_W + 2;
  localparam int unsigned SACC_W = ACC_W - 15;
  localparam int unsigned POUT_W = SAMPLE_W + CFG_W + 1;
  localparam int unsigned SOUT_W = POUT_W - 14;
  localparam int unsigned DIFF_W = DELAY_W + 1;
  localparam int unsigned PDLY_W = DIFF_W + CFG_W + 1;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Saturate a rounded store value
  function automatic logic signed [SAMPLE_W-1:0] sat_acc(logic signed [SACC_W-1:0] x);
    logic [SACC_W-SAMPLE_W:0] top;
    top = x[SACC_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return x[SAMPLE_W-1:0];
    end
    return x[SACC_W-1] ? S_MIN : S_MAX;
  endfunction

  // Saturate a rounded output value
  function automatic logic signed [SAMPLE_W-1:0] sat_out(logic signed [SOUT_W-1:0] x);
    logic [SOUT_W-SAMPLE_W:0] top;
    top = x[SOUT_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return x[SAMPLE_W-1:0];
    end
    return x[SOUT_W-1] ? S_MIN : S_MAX;
  endfunction

  cfg_t cfg;

  sfd_cfg u_sfd_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // Input register and sequencer
  // --------------------------------------------------------------------------
  in_item_t   in_q;
  logic       in_full_q, in_full_d;
  seq_state_e state_q, state_d;
  logic       in_take, out_load, in_acc;

  assign in_stall_o = in_full_q;
  assign in_acc     = in_valid_i && !in_full_q;

  always_comb begin
    state_d  = state_q;
    in_take  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_full_q) state_d = ST_MUL;
      end
      ST_MUL: begin
        in_take = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC:  state_d = ST_RD;
      ST_RD:   state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = in_full_q ? ST_MUL : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) in_full_d = 1'b0;
    if (in_acc)  in_full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_full_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_item_i;
  end

  // --------------------------------------------------------------------------
  // Multiply phase: input, feedback and glide products
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] old_l_q, old_r_q;
  logic signed [GAIN_W-1:0]   gain;
  logic [CFG_W-1:0]           target;
  logic signed [DIFF_W-1:0]   diff;
  logic [DELAY_W-1:0]         delay_q;
  logic signed [PIN_W-1:0]    pin_l, pin_r, pin_l_q, pin_r_q;
  logic signed [PFB_W-1:0]    pfb_l, pfb_r, pfb_l_q, pfb_r_q;
  logic signed [PDLY_W-1:0]   pdly, pdly_q;

  always_comb begin
    gain   = $signed({2'b00, cfg.input_gain}) + GAIN_W'(in_q.gain_mod);
    pin_l  = in_q.left_in * gain;
    pin_r  = in_q.right_in * gain;
    pfb_l  = old_l_q * $signed({1'b0, cfg.feedback_gain});
    pfb_r  = old_r_q * $signed({1'b0, cfg.feedback_gain});
    target = cfg.target_delay + in_q.time_mod;
    diff   = $signed({1'b0, target, 16'd0}) - $signed({1'b0, delay_q});
    pdly   = diff * $signed({1'b0, cfg.smoothing});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      pin_l_q <= pin_l;
      pin_r_q <= pin_r;
      pfb_l_q <= pfb_l;
      pfb_r_q <= pfb_r;
      pdly_q  <= pdly;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate phase: store write, delay glide, next read index
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]    acc_l, acc_r;
  logic signed [SAMPLE_W-1:0] wval_l, wval_r, wval_l_q, wval_r_q;
  logic [DELAY_W-1:0]         delay_d;
  logic [ADDR_W-1:0]          wi_q, wi_inc, rd_idx;
  logic                       wrap_q, fwd_q, vld_q;

  always_comb begin
    acc_l   = {pin_l_q[PIN_W-1], pin_l_q, 1'b0} + ACC_W'(pfb_l_q) + ACC_W'(16384);
    acc_r   = {pin_r_q[PIN_W-1], pin_r_q, 1'b0} + ACC_W'(pfb_r_q) + ACC_W'(16384);
    wval_l  = sat_acc(acc_l[ACC_W-1:15]);
    wval_r  = sat_acc(acc_r[ACC_W-1:15]);
    delay_d = delay_q + pdly_q[DELAY_W+15:16];
    wi_inc  = wi_q + ADDR_W'(1);
    rd_idx  = wi_inc - delay_d[DELAY_W-1 -: ADDR_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q    <= '0;
      wrap_q  <= 1'b0;
      delay_q <= '0;
    end else if (state_q == ST_ACC) begin
      wi_q    <= wi_inc;
      delay_q <= delay_d;
      if (wi_q == {ADDR_W{1'b1}}) wrap_q <= 1'b1;
    end
  end

  // Same-entry read is forwarded; never-written entries read as zero
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      wval_l_q <= wval_l;
      wval_r_q <= wval_r;
      fwd_q    <= (rd_idx == wi_q);
      vld_q    <= wrap_q || (rd_idx <= wi_q);
    end
  end

  logic [2*SAMPLE_W-1:0] ram_rdata;

  sfd_ram #(
    .WIDTH (2*SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_sfd_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_ACC),
    .waddr_i (wi_q),
    .wdata_i ({wval_l, wval_r}),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Read phase: select stored sample, output gain products
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] rd_l, rd_r;
  logic signed [POUT_W-1:0]   pout_l, pout_r, pout_l_q, pout_r_q;

  always_comb begin
    if (fwd_q) begin
      rd_l = wval_l_q;
      rd_r = wval_r_q;
    end else if (vld_q) begin
      rd_l = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
      rd_r = ram_rdata[SAMPLE_W-1:0];
    end else begin
      rd_l = '0;
      rd_r = '0;
    end
    pout_l = rd_l * $signed({1'b0, cfg.output_gain});
    pout_r = rd_r * $signed({1'b0, cfg.output_gain});
  end

  // Sample read here is also the feedback tap of the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_l_q <= '0;
      old_r_q <= '0;
    end else if (state_q == ST_RD) begin
      old_l_q <= rd_l;
      old_r_q <= rd_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      pout_l_q <= pout_l;
      pout_r_q <= pout_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output phase: round, saturate, output register
  // --------------------------------------------------------------------------
  logic signed [POUT_W-1:0] rnd_l, rnd_r;
  out_item_t                out_q;
  logic                     out_valid_q;

  assign rnd_l = pout_l_q + POUT_W'(8192);
  assign rnd_r = pout_r_q + POUT_W'(8192);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.left_out  <= sat_out(rnd_l[POUT_W-1:14]);
      out_q.right_out <= sat_out(rnd_r[POUT_W-1:14]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/sfd_cfg.sv
// ----------------------------------------------------------------------------
// sfd_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sfd_cfg
  import sfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FEEDBACK_GAIN: cfg_d.feedback_gain = cfg_wdata_i;
        CFG_TARGET_DELAY:  cfg_d.target_delay  = cfg_wdata_i;
        CFG_INPUT_GAIN:    cfg_d.input_gain    = cfg_wdata_i;
        CFG_OUTPUT_GAIN:   cfg_d.output_gain   = cfg_wdata_i;
        CFG_SMOOTHING:     cfg_d.smoothing     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_gain <= FEEDBACK_GAIN_RST;
      cfg_q.target_delay  <= TARGET_DELAY_RST;
      cfg_q.input_gain    <= INPUT_GAIN_RST;
      cfg_q.output_gain   <= OUTPUT_GAIN_RST;
      cfg_q.smoothing     <= SMOOTHING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the stereo feedback delay line: handshake hold and
// item accounting between the two channels.
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // The input register fills on every taken item
  a_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // No result without a pending item
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending item");

  // At most input register, sequencer and output register hold items
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("too many items in flight");

endmodule

bind stereo_feedback_delay_line sfd_checker u_sfd_checker (.*);

>>> bench/stereo_feedback_delay_line_tb.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line_tb
// Self-checking bench for the stereo feedback delay line. A bit-exact model
// of the store, the gliding delay and the gain stages predicts every delayed
// sample. Directed items cover extreme samples, gains, zero delay and unused
// register indexes. A long receiver hold-off fills the block, and phases of
// random items run under random register settings, with idle bursts on both
// channels in most phases.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_line_tb;
  import sfd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 50;
  localparam int SETTLE       = 8;
  localparam int S_MAX        = 32767;
  localparam int S_MIN        = -32768;
  localparam int UNITY_Q15    = 32768;
  localparam int UNITY_Q14    = 16384;
  localparam int REG_MAX      = 65535;
  localparam longint CLIP_HI  = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint CLIP_LO  = -CLIP_HI - 1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_FEEDBACK_GAIN;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // Model state
  logic signed [SAMPLE_W-1:0] left_mem  [DEPTH];
  logic signed [SAMPLE_W-1:0] right_mem [DEPTH];
  logic [ADDR_W-1:0]          wr_ptr      = '0;
  logic [ADDR_W-1:0]          rd_ptr      = '0;
  logic [DELAY_W-1:0]         glide_delay = '0;
  cfg_t model_cfg = '{feedback_gain: FEEDBACK_GAIN_RST, target_delay: TARGET_DELAY_RST,
                      input_gain: INPUT_GAIN_RST, output_gain: OUTPUT_GAIN_RST,
                      smoothing: SMOOTHING_RST};

  out_item_t delayed_sample_q [$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        bursts_on      = 1'b1;
  int        hold_cycles    = 0;

  stereo_feedback_delay_line i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Model of the delay line
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] clip_sample(longint x);
    if (x > CLIP_HI) return CLIP_HI[SAMPLE_W-1:0];
    if (x < CLIP_LO) return CLIP_LO[SAMPLE_W-1:0];
    return x[SAMPLE_W-1:0];
  endfunction

  // Input term Q.29 doubled to Q.30 plus feedback Q.30, rounded to Q.15
  function automatic logic signed [SAMPLE_W-1:0] echo_write(
    logic signed [SAMPLE_W-1:0] smp, longint gain, logic signed [SAMPLE_W-1:0] old);
    longint acc;
    acc = longint'(smp) * gain * 2 + longint'(old) * longint'(model_cfg.feedback_gain);
    return clip_sample((acc + 64'sd16384) >>> 15);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] scale_out(logic signed [SAMPLE_W-1:0] s);
    return clip_sample((longint'(s) * longint'(model_cfg.output_gain) + 64'sd8192) >>> 14);
  endfunction

  function automatic out_item_t delay_line_step(in_item_t s);
    longint            gain;
    longint            diff;
    longint            glide;
    logic [15:0]       tgt;
    logic [ADDR_W-1:0] offset;
    out_item_t         r;
    gain = longint'(model_cfg.input_gain) + longint'($signed(s.gain_mod));
    // feedback comes from the previous read position
    left_mem[wr_ptr]  = echo_write(s.left_in, gain, left_mem[rd_ptr]);
    right_mem[wr_ptr] = echo_write(s.right_in, gain, right_mem[rd_ptr]);
    wr_ptr = wr_ptr + 1'b1;
    // glide towards the modulated target, floor of the Q0.16 step
    tgt = model_cfg.target_delay + s.time_mod;
    diff = longint'({tgt, 16'h0000}) - longint'(glide_delay);
    glide = (diff * longint'(model_cfg.smoothing)) >>> 16;
    glide_delay = DELAY_W'(longint'(glide_delay) + glide);
    offset = glide_delay[DELAY_W-1 -: ADDR_W];
    rd_ptr = wr_ptr - offset;
    r.left_out  = scale_out(left_mem[rd_ptr]);
    r.right_out = scale_out(right_mem[rd_ptr]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on each accepted item and
  // checks each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FEEDBACK_GAIN: model_cfg.feedback_gain = cfg_wdata_i;
          CFG_TARGET_DELAY:  model_cfg.target_delay  = cfg_wdata_i;
          CFG_INPUT_GAIN:    model_cfg.input_gain    = cfg_wdata_i;
          CFG_OUTPUT_GAIN:   model_cfg.output_gain   = cfg_wdata_i;
          CFG_SMOOTHING:     model_cfg.smoothing     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        delayed_sample_q.push_back(delay_line_step(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        if (delayed_sample_q.size() == 0) begin
          $error("result with nothing pending: left_out %0d right_out %0d",
                 out_item_o.left_out, out_item_o.right_out);
          mismatch_count++;
        end else begin
          want = delayed_sample_q.pop_front();
          if (out_item_o.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_item_o.left_out);
            mismatch_count++;
          end
          if (out_item_o.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_item_o.right_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rand_word(int span);
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.left_in  = rand_word(8000);
    s.right_in = rand_word(8000);
    s.gain_mod = rand_word(4000);
    s.time_mod = ($urandom_range(0, 3) == 0) ? rand_word(256) : 16'h0000;
    return s;
  endfunction

  function automatic in_item_t make_sample(int l, int r, int g, int t);
    in_item_t s;
    s.left_in  = SAMPLE_W'(l);
    s.right_in = SAMPLE_W'(r);
    s.gain_mod = 16'(g);
    s.time_mod = 16'(t);
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(int lo, int hi, int typical);
    case ($urandom_range(0, 5))
      0:       return CFG_W'(lo);
      1:       return CFG_W'(hi);
      2:       return CFG_W'(typical);
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Offers one item and returns right after the edge that took it
  task automatic offer_sample(in_item_t s);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid and waits until every pending result has come back;
  // one edge first so that the monitor has logged the last item
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (delayed_sample_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Writes all registers; optionally scribbles on the unused indexes too
  task automatic load_regs(int fb, int tgt, int ig, int og, int sm, bit junk);
    cfg_we_i <= 1'b1;
    write_reg(CFG_FEEDBACK_GAIN, CFG_W'(fb));
    write_reg(CFG_TARGET_DELAY, CFG_W'(tgt));
    write_reg(CFG_INPUT_GAIN, CFG_W'(ig));
    write_reg(CFG_OUTPUT_GAIN, CFG_W'(og));
    write_reg(CFG_SMOOTHING, CFG_W'(sm));
    if (junk)
      for (int i = CFG_SMOOTHING + 1; i < 2 ** CFG_IDX_W; i++)
        write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    offer_sample(make_sample(S_MAX, S_MIN, 0, 0));
    offer_sample(make_sample(S_MIN, S_MAX, 0, 0));
    offer_sample(make_sample(1000, -1000, 0, 0));
    drain();
  endtask

  // Target of zero with fast glide: delay settles at zero, oldest sample read
  task automatic test_zero_delay();
    load_regs(UNITY_Q15, 0, UNITY_Q14, UNITY_Q14, REG_MAX, 1'b0);
    offer_sample(make_sample(S_MAX, S_MIN, 0, 0));
    offer_sample(make_sample(S_MIN, S_MAX, 0, 0));
    offer_sample(make_sample(-1, 1, 0, 0));
    offer_sample(make_sample(20000, -20000, 0, 0));
    offer_sample(make_sample(123, -456, 0, 0));
    drain();
  endtask

  // Saturation on the way in and out, then an inverted input gain
  task automatic test_gain_extremes();
    load_regs(UNITY_Q15, 16, REG_MAX, REG_MAX, REG_MAX, 1'b0);
    offer_sample(make_sample(S_MAX, S_MIN, S_MAX, 0));
    offer_sample(make_sample(S_MIN, S_MAX, S_MIN, 0));
    offer_sample(make_sample(S_MAX, S_MAX, S_MIN, 0));
    offer_sample(make_sample(S_MIN, S_MIN, S_MAX, 0));
    drain();
    load_regs(0, 16, 0, UNITY_Q14, REG_MAX, 1'b0);
    offer_sample(make_sample(S_MAX, S_MIN, S_MIN, 0));
    offer_sample(make_sample(10000, -10000, S_MIN, 0));
    drain();
  endtask

  // Writes to unused indexes must leave the register set alone
  task automatic test_unused_registers();
    load_regs(UNITY_Q15 / 2, 2048, UNITY_Q14, UNITY_Q14, REG_MAX, 1'b1);
    offer_sample(make_sample('h5555, 'haaaa, 'h5555, S_MAX));
    offer_sample(make_sample('haaaa, 'h5555, 'haaaa, S_MIN));
    offer_sample(make_sample(S_MAX, S_MIN, 0, 'h5555));
    offer_sample(make_sample(S_MIN, S_MAX, 0, 'haaaa));
    drain();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    bursts_on   = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (24) offer_sample(random_sample());
    drain();
  endtask

  task automatic test_random_traffic();
    int tgt;
    for (int p = 0; p < RAND_PHASES; p++) begin
      // quiet stretch now and then, and none at the end of the run
      bursts_on = (p % 4 != 2) && (p != RAND_PHASES - 1);
      // short delays mostly, so that recent samples and feedback are heard
      tgt = ($urandom_range(0, 3) == 0) ? pick_reg(0, REG_MAX, UNITY_Q15)
                                        : $urandom_range(0, 1200);
      load_regs(pick_reg(0, UNITY_Q15, UNITY_Q15 / 2), tgt,
                pick_reg(0, REG_MAX, UNITY_Q14), pick_reg(0, REG_MAX, UNITY_Q14),
                pick_reg(0, REG_MAX, SMOOTHING_RST), $urandom_range(0, 1));
      repeat (PHASE_ITEMS) offer_sample(random_sample());
      drain();
    end
  endtask

  initial begin
    foreach (left_mem[i]) begin
      left_mem[i]  = '0;
      right_mem[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_delay();
    test_gain_extremes();
    test_unused_registers();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sfd_cfg.sv
sv/stereo_feedback_delay_line.sv
sv/sfd_checker.sv
bench/stereo_feedback_delay_line_tb.sv
